// ===== sv/otb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package otb_pkg;

  // Bank size and counter width.
  localparam int NUM_TIMERS = 16;
  localparam int DELAY_BITS = 16;

  // Widths of the fields on the ports; these are fixed by the interface.
  localparam int FIELD_IDX_W = 4;
  localparam int FIELD_DLY_W = 16;
  localparam int REQ_W       = 2;

  // Address width of the timer memory.
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef logic [REQ_W-1:0]      req_code_t;
  typedef logic [IDX_W-1:0]      addr_t;
  typedef logic [DELAY_BITS-1:0] count_t;

  localparam req_code_t REQ_TICK   = 2'd0;
  localparam req_code_t REQ_ARM    = 2'd1;
  localparam req_code_t REQ_CANCEL = 2'd2;

  // One request as seen by the scan engine.
  typedef struct packed {
    logic                   valid;
    req_code_t              code;
    logic [FIELD_IDX_W-1:0] index;
    logic [FIELD_DLY_W-1:0] delay;
  } otb_req_t;

  // One expiry handed to the output register.
  typedef struct packed {
    logic                   valid;
    logic [FIELD_IDX_W-1:0] index;
    logic                   last;
  } otb_push_t;

endpackage

`default_nettype wire

// ===== sv/otb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module otb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/otb_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module otb_scan
  import otb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire otb_req_t  req,
  output logic           req_ready,
  output otb_push_t      push,
  input  wire logic      push_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam addr_t LAST_ADDR = addr_t'(NUM_TIMERS - 1);

  state_t                 state_r, state_nxt;
  logic [NUM_TIMERS-1:0]  active_r, active_nxt;
  logic                   rd_busy_r, rd_busy_nxt;
  addr_t                  rd_ptr_r, rd_ptr_nxt;
  logic                   proc_valid_r, proc_valid_nxt;
  addr_t                  proc_idx_r, proc_idx_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  addr_t                  pend_idx_r, pend_idx_nxt;

  logic   accept;
  logic   in_range;
  addr_t  req_addr;
  count_t arm_dly;
  count_t arm_val;
  logic   proc_active;
  logic   fires;
  logic   stall;
  logic   issue;
  logic   we;
  addr_t  waddr;
  count_t wdata;
  count_t rdata;

  otb_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (DELAY_BITS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req.valid && req_ready;
  assign in_range  = int'(req.index) < NUM_TIMERS;
  assign req_addr  = addr_t'(req.index);
  assign arm_dly   = count_t'(req.delay);
  assign arm_val   = (arm_dly == '0) ? count_t'(1) : arm_dly;

  // The entry in the read data register is decremented; it expires when it held one.
  assign proc_active = active_r[proc_idx_r];
  assign fires       = proc_valid_r && proc_active && (rdata == count_t'(1));
  // A second expiry needs the held one sent out first.
  assign stall       = fires && pend_valid_r && !push_ready;
  assign issue       = (state_r == S_SCAN) && rd_busy_r && !stall;

  always_comb begin
    if (state_r == S_SCAN) begin
      we    = proc_valid_r && proc_active && !stall;
      waddr = proc_idx_r;
      wdata = rdata - count_t'(1);
    end else begin
      we    = accept && (req.code == REQ_ARM) && in_range && !active_r[req_addr];
      waddr = req_addr;
      wdata = arm_val;
    end
  end

  assign push.valid = pend_valid_r &&
                      (((state_r == S_SCAN) && fires) || (state_r == S_DONE));
  assign push.index = FIELD_IDX_W'(pend_idx_r);
  assign push.last  = (state_r == S_DONE);

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    rd_busy_nxt    = rd_busy_r;
    rd_ptr_nxt     = rd_ptr_r;
    proc_valid_nxt = proc_valid_r;
    proc_idx_nxt   = proc_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req.code)
            REQ_ARM: begin
              if (in_range && !active_r[req_addr]) begin
                active_nxt[req_addr] = 1'b1;
              end
            end
            REQ_CANCEL: begin
              if (in_range) begin
                active_nxt[req_addr] = 1'b0;
              end
            end
            REQ_TICK: begin
              state_nxt   = S_SCAN;
              rd_busy_nxt = 1'b1;
              rd_ptr_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          if (rd_ptr_r == LAST_ADDR) begin
            rd_busy_nxt = 1'b0;
          end else begin
            rd_ptr_nxt = rd_ptr_r + addr_t'(1);
          end
        end
        if (!stall) begin
          proc_valid_nxt = issue;
          proc_idx_nxt   = rd_ptr_r;
          if (fires) begin
            active_nxt[proc_idx_r] = 1'b0;
            pend_valid_nxt         = 1'b1;
            pend_idx_nxt           = proc_idx_r;
          end
          if (proc_valid_r && (proc_idx_r == LAST_ADDR)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (push_ready) begin
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      rd_busy_r    <= 1'b0;
      proc_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      rd_busy_r    <= rd_busy_nxt;
      proc_valid_r <= proc_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    rd_ptr_r   <= rd_ptr_nxt;
    proc_idx_r <= proc_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/one_shot_timer_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bank of NUM_TIMERS one-shot countdown timers with a request stream in and an
// expiry stream out.
// Input items carry the request kind in in_tuser (0 tick, 1 arm, 2 cancel) and
// the timer index and delay in in_tdata. An arm loads an idle timer with its
// delay (a delay of zero counts as one); an arm of a running timer is dropped.
// A cancel stops the timer. Arm and cancel items leave the block ready for the
// next request. A tick walks the timer memory one entry per cycle while the scan
// is not paused, decrementing every running timer. After a tick is accepted,
// in_tready stays low until the walk is over and any held expiry has gone to the
// output register. The count memory takes one read and one write per cycle, and
// the walk can pause while the receiver stalls. Each timer that reaches zero
// produces one output item with its index; the final expiry of the tick is
// marked with out_tlast. An expiry is held back until the next one is found, so
// out_tlast is known when it leaves. A tick with no expiry produces nothing.
// The output register lets the scan continue while a result waits; when the
// receiver stalls and a second expiry is already held, the scan pauses.
// Reset clears all running flags, so every timer is idle; counts are undefined
// until armed.

module one_shot_timer_bank
  import otb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [3:0] timer_index, [19:4] delay_ticks
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [3:0] fired_index
  output logic             out_tlast   // last_fired
);

  otb_req_t  req;
  otb_push_t push;
  logic      push_ready;

  logic                   out_valid_r;
  logic [FIELD_IDX_W-1:0] out_index_r;
  logic                   out_last_r;

  assign req.valid = in_tvalid;
  assign req.code  = in_tuser;
  assign req.index = in_tdata[FIELD_IDX_W-1:0];
  assign req.delay = in_tdata[FIELD_IDX_W +: FIELD_DLY_W];

  otb_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_ready  (in_tready),
    .push       (push),
    .push_ready (push_ready)
  );

  // Output register: takes a new expiry whenever it is empty or being drained.
  assign push_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid && push_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (push.valid && push_ready) begin
      out_index_r <= push.index;
      out_last_r  <= push.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_index_r);
  assign out_tlast  = out_last_r;

  // A tick keeps the block busy in the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == REQ_TICK)) |=> !in_tready)
    else $error("tick accepted but block ready again at once");

  // Expiries are only produced during a tick, never while taking requests.
  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !in_tready)
    else $error("expiry produced while idle");

  // Every reported index names a timer of the bank.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_index_r) < NUM_TIMERS))
    else $error("fired index out of range");

endmodule

`default_nettype wire

// ===== test/expiry_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the timer bank, keeps its own copy of the timer
// state, and compares every expiry leaving the block with the predicted one.
module expiry_checker
  import otb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        out_tlast,
  output int               errors,
  output int               pending,
  output int               fired_seen,
  output int               widest_tick
);

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] index;
    logic                   last;
  } expiry_t;

  logic    running   [NUM_TIMERS];
  count_t  remaining [NUM_TIMERS];
  expiry_t due_expiries[$];

  // Applies one request to the shadow bank and queues the expiries it causes.
  task automatic apply_request(input req_code_t code, input logic [FIELD_IDX_W-1:0] idx,
                               input count_t dly);
    logic [NUM_TIMERS-1:0] hit;
    int                    last_i;
    int                    n;
    expiry_t               e;
    hit    = '0;
    last_i = -1;
    n      = 0;
    case (code)
      REQ_ARM: begin
        if (idx < NUM_TIMERS && !running[idx]) begin
          remaining[idx] = (dly == '0) ? count_t'(1) : dly;
          running[idx]   = 1'b1;
        end
      end
      REQ_CANCEL: begin
        if (idx < NUM_TIMERS) running[idx] = 1'b0;
      end
      REQ_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (running[i]) begin
            remaining[i] = remaining[i] - count_t'(1);
            if (remaining[i] == '0) begin
              running[i] = 1'b0;
              hit[i]     = 1'b1;
              last_i     = i;
              n++;
            end
          end
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (hit[i]) begin
            e.index = FIELD_IDX_W'(i);
            e.last  = (i == last_i);
            due_expiries.push_back(e);
          end
        end
        if (n > widest_tick) widest_tick = n;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    expiry_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) running[i] = 1'b0;
      due_expiries.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        fired_seen++;
        if (due_expiries.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected expiry: index %0d last %0b", $realtime,
                     out_tdata[FIELD_IDX_W-1:0], out_tlast);
        end else begin
          want = due_expiries.pop_front();
          if (out_tdata[FIELD_IDX_W-1:0] !== want.index || out_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: expiry mismatch: expected index %0d last %0b, got index %0d last %0b",
                       $realtime, want.index, want.last, out_tdata[FIELD_IDX_W-1:0],
                       out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_request(in_tuser, in_tdata[FIELD_IDX_W-1:0],
                      in_tdata[FIELD_IDX_W +: FIELD_DLY_W]);
    end
    pending = due_expiries.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Top of the timer bank testbench. It resets the block, drives the request
// stream and paces the expiry stream; the checker beside the block does all
// prediction and comparison and reports its failure count back here.
module testbench;
  import otb_pkg::*;

  // The block ignores this request code; it has no name in the package.
  localparam req_code_t REQ_UNDEF = 2'd3;

  // Length of the deliberate output stall used to back up the request stream.
  localparam int HOLD_OFF_CYCLES = 400;
  // Cycles without any accepted item before the run is declared hung. The
  // longest correct quiet stretch is the deliberate stall above.
  localparam int STALL_LIMIT = 5000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int errors;
  int pending;
  int fired_seen;
  int widest_tick;

  // Random idling on both sides is on unless a phase turns it off.
  bit idle_on  = 1'b1;
  // Raised by the request side to ask the receiver for one long stall.
  bit hold_req = 1'b0;

  int sent_by_code [4];
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  one_shot_timer_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  expiry_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .errors      (errors),
    .pending     (pending),
    .fired_seen  (fired_seen),
    .widest_tick (widest_tick)
  );

  // Offers one request and returns at the edge where it is accepted. The valid
  // line stays high into the next request unless an idle gap is drawn, so it
  // never gets two assignments in one time step.
  task automatic send_req(input req_code_t code, input logic [3:0] idx,
                          input logic [15:0] dly);
    if (idle_on) begin
      while ($urandom_range(99) < 18) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {4'b0000, dly, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_by_code[code]++;
  endtask

  // A tick ignores its index and delay, so those carry noise.
  task automatic send_tick();
    send_req(REQ_TICK, 4'($urandom), 16'($urandom));
  endtask

  // Mostly short delays so that timers expire often and ticks fire several at
  // once; now and then a full-width delay that only a cancel will end.
  task automatic send_random();
    int          roll;
    int          span;
    logic [15:0] dly;
    roll = $urandom_range(99);
    span = $urandom_range(9);
    if (span < 7)
      dly = 16'($urandom_range(6));
    else if (span < 9)
      dly = 16'($urandom_range(40));
    else
      dly = 16'($urandom);
    if (roll < 40)
      send_tick();
    else if (roll < 80)
      send_req(REQ_ARM, 4'($urandom), dly);
    else if (roll < 97)
      send_req(REQ_CANCEL, 4'($urandom), 16'($urandom));
    else
      send_req(REQ_UNDEF, 4'($urandom), 16'($urandom));
  endtask

  // Receiver pacing. A long stall is taken once on request; otherwise the
  // ready line drops at random while idling is enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_tready <= !idle_on || ($urandom_range(99) >= 18);
      end
    end
  end

  // Hang detection: any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No item accepted for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A tick on an empty bank must stay silent.
    send_tick();
    // Zero delay counts as one; timers 0 and 15 expire on the same tick, with
    // the higher index carrying the last mark, and timer 5 alone on the next.
    send_req(REQ_ARM, 4'd0, 16'd0);
    send_req(REQ_ARM, 4'd15, 16'd1);
    send_req(REQ_ARM, 4'd5, 16'd2);
    send_tick();
    send_tick();
    // A second arm of a running timer must not reload its count.
    send_req(REQ_ARM, 4'd3, 16'd3);
    send_req(REQ_ARM, 4'd3, 16'd1);
    send_tick();
    send_tick();
    send_tick();
    // Full-width delays of all ones and alternating bit patterns, then cancelled; the
    // ticks in between must not report them.
    send_req(REQ_ARM, 4'd7, 16'hFFFF);
    send_req(REQ_ARM, 4'd10, 16'hAAAA);
    send_req(REQ_ARM, 4'd11, 16'h5555);
    send_tick();
    send_req(REQ_CANCEL, 4'd7, 16'h0000);
    send_req(REQ_CANCEL, 4'd10, 16'hFFFF);
    send_req(REQ_CANCEL, 4'd11, 16'h0000);
    // Cancel of an idle timer does nothing; the undefined code is ignored
    // even when it names a running timer.
    send_req(REQ_CANCEL, 4'd9, 16'd0);
    send_req(REQ_ARM, 4'd12, 16'd1);
    send_req(REQ_UNDEF, 4'd12, 16'hFFFF);
    send_tick();
    send_tick();

    // Random traffic with idling on both sides.
    repeat (180) send_random();

    // A long stretch with neither side idling.
    idle_on = 1'b0;
    repeat (90) send_random();
    idle_on = 1'b1;

    // Back-pressure: the receiver stalls for a long time while every timer is
    // set to expire on one tick, twice over, so the block holds its results
    // and stops taking requests.
    hold_req = 1'b1;
    repeat (2) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        send_req(REQ_CANCEL, 4'(i), 16'($urandom));
        send_req(REQ_ARM, 4'(i), 16'd1);
      end
      send_tick();
    end

    repeat (110) send_random();
    in_tvalid <= 1'b0;

    // Drain: all expiries in, then let a final scan finish.
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d ticks, %0d arms, %0d cancels and %0d ignored requests.",
             sent_by_code[REQ_TICK], sent_by_code[REQ_ARM], sent_by_code[REQ_CANCEL],
             sent_by_code[REQ_UNDEF]);
    $display("Checked %0d expiries, up to %0d on one tick, with a long output stall.",
             fired_seen, widest_tick);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d expiries still outstanding", errors, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/otb_pkg.sv
sv/otb_ram.sv
sv/otb_scan.sv
sv/one_shot_timer_bank.sv
test/expiry_checker.sv
test/testbench.sv
